[hw/rtl/bclpd_pkg.sv]
// Shared types, reset values and register codes of the button click and long-press detector.
package bclpd_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int NOW_WIDTH      = 32;
	localparam int CFG_WIDTH      = 16;
	localparam int CFG_IDX_WIDTH  = 2;

	localparam logic        IDLE_LEVEL_RST        = 1'b1;
	localparam logic [15:0] FILTER_MS_RST         = 16'd20;
	localparam logic [15:0] LONG_PRESS_MS_RST     = 16'd2000;
	localparam logic        LONG_PRESS_ENABLE_RST = 1'b0;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_IDLE_LEVEL        = 2'd0,
		REG_FILTER_MS         = 2'd1,
		REG_LONG_PRESS_MS     = 2'd2,
		REG_LONG_PRESS_ENABLE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic                 pin_level;
		logic [NOW_WIDTH-1:0] now_ms;
	} in_beat_t;

	typedef struct packed {
		logic fall_event;
		logic rise_event;
		logic release_event;
		logic idle_event;
		logic long_press_event;
		logic click_event;
		logic active_event;
		logic released_flag;
		logic tracked_level;
	} out_beat_t;

	typedef struct packed {
		logic        idle_level;
		logic [15:0] filter_ms;
		logic [15:0] long_press_ms;
		logic        long_press_enable;
	} cfg_t;

	typedef struct packed {
		logic level;
		logic pending;
		logic press;
		logic long_hold;
		logic released;
	} flags_t;

endpackage

[hw/rtl/bclpd_cfg.sv]
// Configuration registers and the detector restart strobe.
module bclpd_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bclpd_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [bclpd_pkg::CFG_WIDTH-1:0]     cfg_wdata,
	output bclpd_pkg::cfg_t                     cfg,
	output logic                                restart
);

	bclpd_pkg::cfg_t cfg_q;

	assign cfg     = cfg_q;
	assign restart = cfg_we && (bclpd_pkg::reg_idx_t'(cfg_index) == bclpd_pkg::REG_IDLE_LEVEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_level        <= bclpd_pkg::IDLE_LEVEL_RST;
			cfg_q.filter_ms         <= bclpd_pkg::FILTER_MS_RST;
			cfg_q.long_press_ms     <= bclpd_pkg::LONG_PRESS_MS_RST;
			cfg_q.long_press_enable <= bclpd_pkg::LONG_PRESS_ENABLE_RST;
		end else if (cfg_we) begin
			unique case (bclpd_pkg::reg_idx_t'(cfg_index))
				bclpd_pkg::REG_IDLE_LEVEL:        cfg_q.idle_level <= cfg_wdata[0];
				bclpd_pkg::REG_FILTER_MS:         cfg_q.filter_ms <= cfg_wdata;
				bclpd_pkg::REG_LONG_PRESS_MS:     cfg_q.long_press_ms <= cfg_wdata;
				bclpd_pkg::REG_LONG_PRESS_ENABLE: cfg_q.long_press_enable <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

endmodule

[hw/rtl/bclpd_step.sv]
// Combinational update of the detector state and result for one poll.
module bclpd_step #(
	parameter int TIME_WIDTH = bclpd_pkg::TIME_WIDTH_DEF
) (
	input  bclpd_pkg::in_beat_t  in_beat,
	input  bclpd_pkg::cfg_t      cfg,
	input  bclpd_pkg::flags_t    flags,
	input  logic [TIME_WIDTH-1:0] change_time,
	output bclpd_pkg::flags_t    flags_nxt,
	output logic [TIME_WIDTH-1:0] change_time_nxt,
	output bclpd_pkg::out_beat_t out_beat
);

	logic [TIME_WIDTH-1:0] now_w;
	logic [TIME_WIDTH-1:0] elapsed;

	assign now_w   = TIME_WIDTH'(in_beat.now_ms);
	assign elapsed = now_w - change_time_nxt;

	always_comb begin
		flags_nxt       = flags;
		change_time_nxt = change_time;
		out_beat        = '0;

		if (in_beat.pin_level != flags.level) begin
			if (!flags.pending) begin
				change_time_nxt   = now_w;
				flags_nxt.pending = 1'b1;
			end else begin
				flags_nxt.level     = !flags.level;
				out_beat.fall_event = flags.level;
				out_beat.rise_event = !flags.level;
				flags_nxt.pending   = 1'b0;
			end
		end

		if (flags_nxt.level == cfg.idle_level) begin
			if (flags.press && !flags.long_hold) begin
				flags_nxt.released     = 1'b1;
				out_beat.release_event = 1'b1;
			end
			flags_nxt.press     = 1'b0;
			out_beat.idle_event = 1'b1;
		end else if (elapsed > TIME_WIDTH'(cfg.filter_ms)) begin
			if (cfg.long_press_enable) begin
				if (elapsed < TIME_WIDTH'(cfg.long_press_ms)) begin
					flags_nxt.press     = 1'b1;
					flags_nxt.long_hold = 1'b0;
				end else if (!flags.long_hold) begin
					if (flags.press) begin
						flags_nxt.long_hold       = 1'b1;
						out_beat.long_press_event = 1'b1;
					end
					flags_nxt.released = 1'b0;
				end
			end else if (!flags.press) begin
				flags_nxt.press      = 1'b1;
				out_beat.click_event = 1'b1;
			end
			out_beat.active_event = 1'b1;
		end

		out_beat.released_flag = flags_nxt.released;
		out_beat.tracked_level = flags_nxt.level;
	end

endmodule

[hw/rtl/button_click_long_press_detector_unit.sv]
// Top level of the button click and long-press detector.
// Each input beat is one poll of the button pin with its millisecond time stamp, and each
// poll yields exactly one result beat. The block takes one beat per clock cycle as long as
// results are taken when offered. A poll is held in the input register, the state update
// is done in the path between it and the result register, and the result is loaded into
// the result register once that register is empty or being read. While a result waits,
// the input register can still take one poll, after which the input side stalls until the
// result is taken. Writing the idle level restarts the detector at that level.
module button_click_long_press_detector_unit #(
	parameter int TIME_WIDTH = bclpd_pkg::TIME_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  bclpd_pkg::in_beat_t                 in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output bclpd_pkg::out_beat_t                out_data,
	input  logic                                cfg_we,
	input  logic [bclpd_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [bclpd_pkg::CFG_WIDTH-1:0]     cfg_wdata
);

	bclpd_pkg::cfg_t      cfg;
	logic                 restart;
	bclpd_pkg::in_beat_t  in_s1;
	logic                 valid_s1;
	bclpd_pkg::flags_t    flags_q;
	bclpd_pkg::flags_t    flags_nxt;
	logic [TIME_WIDTH-1:0] change_time_q;
	logic [TIME_WIDTH-1:0] change_time_nxt;
	bclpd_pkg::out_beat_t result;
	bclpd_pkg::out_beat_t out_data_q;
	logic                 out_valid_q;
	logic                 advance;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	bclpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg),
		.restart   (restart)
	);

	bclpd_step #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_step (
		.in_beat         (in_s1),
		.cfg             (cfg),
		.flags           (flags_q),
		.change_time     (change_time_q),
		.flags_nxt       (flags_nxt),
		.change_time_nxt (change_time_nxt),
		.out_beat        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
		if (advance) begin
			out_data_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q.level     <= bclpd_pkg::IDLE_LEVEL_RST;
			flags_q.pending   <= 1'b0;
			flags_q.press     <= 1'b0;
			flags_q.long_hold <= 1'b0;
			flags_q.released  <= 1'b0;
			change_time_q     <= '0;
		end else if (restart) begin
			flags_q.level     <= cfg_wdata[0];
			flags_q.press     <= 1'b0;
			flags_q.long_hold <= 1'b0;
			flags_q.released  <= 1'b0;
		end else if (advance) begin
			flags_q       <= flags_nxt;
			change_time_q <= change_time_nxt;
		end
	end

endmodule

[test/button_click_long_press_detector_unit_tb.sv]
// Self-checking testbench for the button click and long-press detector: polls, events, settings.
module button_click_long_press_detector_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_ready;
	bclpd_pkg::in_beat_t                 in_data;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	bclpd_pkg::out_beat_t                out_data;
	logic                                cfg_we;
	logic [bclpd_pkg::CFG_IDX_WIDTH-1:0] cfg_index;
	logic [bclpd_pkg::CFG_WIDTH-1:0]     cfg_wdata;

	logic        m_idle;
	logic [15:0] m_filter;
	logic [15:0] m_long_ms;
	logic        m_long_en;
	logic        trk_level;
	logic        chg_pending;
	logic [31:0] chg_time;
	logic        press_seen;
	logic        long_seen;
	logic        rel_seen;

	bclpd_pkg::out_beat_t predicted_events[$];
	int          mismatches = 0;
	int          polls_sent = 0;
	int          burst_left = 0;
	int          stall_mode = 0;
	int          stall_left = 0;
	logic [31:0] poll_time = '0;

	button_click_long_press_detector_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void reset_model();
		m_idle      = bclpd_pkg::IDLE_LEVEL_RST;
		m_filter    = bclpd_pkg::FILTER_MS_RST;
		m_long_ms   = bclpd_pkg::LONG_PRESS_MS_RST;
		m_long_en   = bclpd_pkg::LONG_PRESS_ENABLE_RST;
		trk_level   = bclpd_pkg::IDLE_LEVEL_RST;
		chg_pending = 1'b0;
		chg_time    = '0;
		press_seen  = 1'b0;
		long_seen   = 1'b0;
		rel_seen    = 1'b0;
	endfunction

	function automatic bclpd_pkg::out_beat_t detect_events(input logic pin,
		input logic [31:0] stamp);
		bclpd_pkg::out_beat_t r;
		logic [31:0]          held;
		r = '0;
		if (pin != trk_level) begin
			if (!chg_pending) begin
				chg_time    = stamp;
				chg_pending = 1'b1;
			end else begin
				if (trk_level) begin
					trk_level    = 1'b0;
					r.fall_event = 1'b1;
				end else begin
					trk_level    = 1'b1;
					r.rise_event = 1'b1;
				end
				chg_pending = 1'b0;
			end
		end
		held = stamp - chg_time;
		if (trk_level == m_idle) begin
			if (press_seen && !long_seen) begin
				rel_seen        = 1'b1;
				r.release_event = 1'b1;
			end
			press_seen   = 1'b0;
			r.idle_event = 1'b1;
		end else if (held > {16'd0, m_filter}) begin
			if (m_long_en) begin
				if (held < {16'd0, m_long_ms}) begin
					press_seen = 1'b1;
					long_seen  = 1'b0;
				end else if (!long_seen) begin
					if (press_seen) begin
						long_seen          = 1'b1;
						r.long_press_event = 1'b1;
					end
					rel_seen = 1'b0;
				end
			end else if (!press_seen) begin
				press_seen    = 1'b1;
				r.click_event = 1'b1;
			end
			r.active_event = 1'b1;
		end
		r.released_flag = rel_seen;
		r.tracked_level = trk_level;
		return r;
	endfunction

	function automatic string field_name(input int b);
		case (b)
			8: return "fall_event";
			7: return "rise_event";
			6: return "release_event";
			5: return "idle_event";
			4: return "long_press_event";
			3: return "click_event";
			2: return "active_event";
			1: return "released_flag";
			default: return "tracked_level";
		endcase
	endfunction

	function automatic logic [15:0] pick_ms();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(1, 60));
			4: return 16'($urandom_range(61, 3000));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_poll(input logic pin, input logic [31:0] stamp);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid          = 1'b1;
		in_data.pin_level = pin;
		in_data.now_ms    = stamp;
		do @(posedge clk); while (in_ready !== 1'b1);
		predicted_events.push_back(detect_events(pin, stamp));
		polls_sent++;
		@(negedge clk);
	endtask

	task automatic wait_results_done();
		in_valid   = 1'b0;
		burst_left = 0;
		while (predicted_events.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input bclpd_pkg::reg_idx_t idx, input logic [15:0] value);
		wait_results_done();
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		case (idx)
			bclpd_pkg::REG_IDLE_LEVEL: begin
				m_idle     = value[0];
				trk_level  = value[0];
				press_seen = 1'b0;
				long_seen  = 1'b0;
				rel_seen   = 1'b0;
			end
			bclpd_pkg::REG_FILTER_MS:     m_filter  = value;
			bclpd_pkg::REG_LONG_PRESS_MS: m_long_ms = value;
			default:                      m_long_en = value[0];
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic test_click_mode();
		send_poll(1'b1, 32'd0);
		send_poll(1'b0, 32'd5);
		send_poll(1'b1, 32'd6);
		send_poll(1'b0, 32'd7);
		send_poll(1'b0, 32'd25);
		send_poll(1'b0, 32'd26);
		send_poll(1'b1, 32'd41);
		send_poll(1'b1, 32'd42);
	endtask

	task automatic test_long_press();
		write_reg(bclpd_pkg::REG_FILTER_MS, 16'd0);
		write_reg(bclpd_pkg::REG_LONG_PRESS_MS, 16'd30);
		write_reg(bclpd_pkg::REG_LONG_PRESS_ENABLE, 16'd1);
		send_poll(1'b0, 32'd1000);
		send_poll(1'b0, 32'd1001);
		send_poll(1'b0, 32'd1029);
		send_poll(1'b0, 32'd1030);
		send_poll(1'b1, 32'd1040);
		send_poll(1'b1, 32'd1041);
	endtask

	task automatic test_time_wrap();
		write_reg(bclpd_pkg::REG_FILTER_MS, 16'hFFFF);
		write_reg(bclpd_pkg::REG_LONG_PRESS_ENABLE, 16'd0);
		send_poll(1'b0, 32'hFFFF_FFF0);
		send_poll(1'b0, 32'hFFFF_FFF1);
		send_poll(1'b0, 32'h0000_FFEF);
		send_poll(1'b0, 32'h0000_FFF0);
		send_poll(1'b1, 32'h7FFF_FFFF);
		send_poll(1'b1, 32'h8000_0000);
	endtask

	task automatic test_idle_low();
		write_reg(bclpd_pkg::REG_IDLE_LEVEL, 16'hFFFE);
		write_reg(bclpd_pkg::REG_FILTER_MS, 16'd20);
		send_poll(1'b1, 32'd100);
		send_poll(1'b1, 32'd101);
		send_poll(1'b1, 32'd200);
		send_poll(1'b0, 32'd201);
		send_poll(1'b0, 32'd202);
	endtask

	task automatic test_random_polls();
		int          phase;
		int          goal;
		int          holds;
		logic        active;
		logic [31:0] base;
		logic [31:0] offset;
		logic [31:0] span;
		phase = 0;
		goal  = polls_sent + 1000;
		while (polls_sent < goal) begin
			case (phase)
				0: begin
					write_reg(bclpd_pkg::REG_FILTER_MS, 16'd0);
					write_reg(bclpd_pkg::REG_LONG_PRESS_MS, 16'd0);
				end
				1: begin
					write_reg(bclpd_pkg::REG_FILTER_MS, 16'hFFFF);
					write_reg(bclpd_pkg::REG_LONG_PRESS_MS, 16'hFFFF);
				end
				default: begin
					write_reg(bclpd_pkg::REG_FILTER_MS, pick_ms());
					write_reg(bclpd_pkg::REG_LONG_PRESS_MS, pick_ms());
				end
			endcase
			write_reg(bclpd_pkg::REG_IDLE_LEVEL, 16'($urandom));
			write_reg(bclpd_pkg::REG_LONG_PRESS_ENABLE, 16'($urandom));
			repeat (12) begin
				if ($urandom_range(0, 9) < 6) begin
					active = ~m_idle;
					poll_time += $urandom_range(1, 40);
					send_poll(active, poll_time);
					poll_time += $urandom_range(0, 5);
					send_poll(active, poll_time);
					base   = chg_time;
					span   = 32'((m_filter > m_long_ms) ? m_filter : m_long_ms) + 32'd8;
					offset = poll_time - base;
					holds  = $urandom_range(1, 8);
					repeat (holds) begin
						case ($urandom_range(0, 7))
							0: offset = 32'(m_filter);
							1: offset = 32'(m_filter) + 32'd1;
							2: offset = 32'(m_long_ms) - 32'd1;
							3: offset = 32'(m_long_ms);
							default: offset = offset + $urandom_range(0, span / 2);
						endcase
						if ($urandom_range(0, 15) == 0)
							write_reg(bclpd_pkg::reg_idx_t'($urandom_range(0, 3)), pick_ms());
						send_poll(($urandom_range(0, 9) == 0) ? m_idle : active, base + offset);
					end
					poll_time = base + offset;
					repeat (2) begin
						poll_time += $urandom_range(0, 30);
						send_poll(m_idle, poll_time);
					end
				end else begin
					repeat ($urandom_range(1, 6)) begin
						case ($urandom_range(0, 15))
							0, 1: poll_time = $urandom;
							2: poll_time = 32'hFFFF_FFFF - $urandom_range(0, 40);
							default: poll_time += $urandom_range(0, 60);
						endcase
						send_poll(1'($urandom_range(0, 1)), poll_time);
					end
				end
				if ($urandom_range(0, 29) == 0)
					wait_results_done();
			end
			phase++;
		end
	endtask

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 120);
		end
		stall_left--;
		case (stall_mode)
			0: out_ready = 1'b1;
			1: out_ready = 1'($urandom_range(0, 1));
			2: out_ready = ($urandom_range(0, 3) == 0);
			default: out_ready = ((stall_left % 16) < 12);
		endcase
	end

	always @(posedge clk) begin
		bclpd_pkg::out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (predicted_events.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual %b", $time, out_data);
				mismatches++;
			end else begin
				want = predicted_events.pop_front();
				for (int b = 8; b >= 0; b--) begin
					if (out_data[b] !== want[b]) begin
						$display("%0t: %s expected %b actual %b", $time, field_name(b),
							want[b], out_data[b]);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = bclpd_pkg::REG_IDLE_LEVEL;
		cfg_wdata = '0;
		reset_model();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_click_mode();
		test_long_press();
		test_time_wrap();
		test_idle_low();
		test_random_polls();
		wait_results_done();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/bclpd_pkg.sv
hw/rtl/bclpd_cfg.sv
hw/rtl/bclpd_step.sv
hw/rtl/button_click_long_press_detector_unit.sv
test/button_click_long_press_detector_unit_tb.sv
